>>> rtl/core/lobe_pkg.sv
// Shared types and constants for the limit order book engine.
package lobe_pkg;

    localparam int NUM_ORDERS = 1024;
    localparam int NUM_LEVELS = 256;
    localparam int ID_W       = $clog2(NUM_ORDERS);
    localparam int LV_W       = $clog2(NUM_LEVELS);
    localparam int TOT_W      = 42;
    localparam int QTY_W      = 32;

    localparam logic [7:0] OP_ADD     = 8'd0;
    localparam logic [7:0] OP_REDUCE  = 8'd1;
    localparam logic [7:0] OP_CANCEL  = 8'd2;

    typedef enum logic [2:0] {
        ST_APPLIED   = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_ADD_REF   = 3'd2,
        ST_NOT_LIVE  = 3'd3,
        ST_BAD_OP    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_ADD    = 2'd0,
        K_REDUCE = 2'd1,
        K_REJECT = 2'd2
    } t_kind;

    // One classified command passed from the front to the back.
    typedef struct packed {
        t_kind             kind;
        t_status           rej_status;
        logic              report_order;
        logic [ID_W-1:0]   id;
        logic              is_ask;
        logic [LV_W-1:0]   price;
        logic [QTY_W-1:0]  amount;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic              live;
        logic [QTY_W-1:0]  left;
        logic [15:0]       top_bid;
        logic              bid_present;
        logic [15:0]       top_ask;
        logic              ask_present;
    } t_result;

endpackage

>>> rtl/core/lobe_front.sv
// Front end: accepts input beats, range-checks them and queues commands.
module lobe_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_operation,
    input  logic [15:0]          i_order_ref,
    input  logic                 i_is_ask,
    input  logic [15:0]          i_price_level,
    input  logic [31:0]          i_amount,
    output logic                 o_cmd_valid,
    output lobe_pkg::t_cmd       o_cmd,
    input  logic                 i_cmd_take
);
    import lobe_pkg::*;

    // Two-entry command queue.
    t_cmd r_q [2];
    logic r_rd;
    logic r_wr;
    logic [1:0] r_cnt;
    t_cmd n_cmd;
    logic acc;
    logic take;

    always_comb begin
        n_cmd = '0;
        n_cmd.id = i_order_ref[ID_W-1:0];
        n_cmd.is_ask = i_is_ask;
        n_cmd.price = i_price_level[LV_W-1:0];
        n_cmd.amount = i_amount;
        n_cmd.report_order = 1'b1;
        n_cmd.kind = K_REJECT;
        n_cmd.rej_status = ST_APPLIED;
        if (i_order_ref >= 16'(NUM_ORDERS)) begin
            n_cmd.rej_status = ST_BAD_ID;
            n_cmd.report_order = 1'b0;
        end else if (i_operation == OP_ADD) begin
            if (i_price_level >= 16'(NUM_LEVELS)) begin
                n_cmd.rej_status = ST_ADD_REF;
            end else begin
                n_cmd.kind = K_ADD;
            end
        end else if (i_operation == OP_REDUCE || i_operation == OP_CANCEL) begin
            n_cmd.kind = K_REDUCE;
        end else begin
            n_cmd.rej_status = ST_BAD_OP;
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign acc = i_push && !o_full;
    assign take = i_cmd_take && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wr <= ~r_wr;
            end
            if (take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, take};
        end
    end
endmodule

>>> rtl/core/lobe_back.sv
// Back end: order table and level totals updates, top-of-book search, result queue.
module lobe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  lobe_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output lobe_pkg::t_result    o_res
);
    import lobe_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_LVL, S_WRITE, S_SCAN, S_DONE
    } t_state;

    // Order table memory: {valid, side, price, qty}, cleared by a pass after reset.
    logic [LV_W+QTY_W+1:0] r_ent_mem [NUM_ORDERS];
    logic [TOT_W-1:0] r_bid_mem [NUM_LEVELS];
    logic [TOT_W-1:0] r_ask_mem [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] r_bid_nz;
    logic [NUM_LEVELS-1:0] r_ask_nz;

    t_state r_state;
    t_cmd r_cmd;
    logic [LV_W+QTY_W+1:0] r_ent;
    logic [ID_W-1:0] r_clr;
    logic [TOT_W-1:0] r_tot;
    logic r_side;
    logic [LV_W-1:0] r_lvl;
    logic [QTY_W-1:0] r_cut;
    logic [LV_W:0] r_scan;
    logic [LV_W-1:0] r_bb, r_ba;
    logic r_bp, r_ap;
    t_status r_status;
    logic r_live;
    logic [QTY_W-1:0] r_left;

    // Result queue, two entries.
    t_result r_rq [2];
    logic r_rq_rd, r_rq_wr;
    logic [1:0] r_rq_cnt;

    logic pop_acc;
    logic [QTY_W-1:0] e_qty;
    logic e_side;
    logic e_valid;
    logic [LV_W-1:0] e_price;
    logic [LV_W-1:0] lo_idx, hi_idx;
    logic upd;
    t_result n_res;

    assign e_qty = r_ent[QTY_W-1:0];
    assign e_price = r_ent[LV_W+QTY_W-1:QTY_W];
    assign e_side = r_ent[LV_W+QTY_W];
    assign e_valid = r_ent[LV_W+QTY_W+1];
    assign lo_idx = r_scan[LV_W-1:0];
    assign hi_idx = LV_W'(NUM_LEVELS - 1) - r_scan[LV_W-1:0];
    // Only an accepted add or a reduce of a live order touches the stores.
    assign upd = (r_cmd.kind == K_ADD && !e_valid) || (r_cmd.kind == K_REDUCE && e_valid);

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && (r_rq_cnt != 2'd2);
    assign pop_acc = i_pop && !o_empty;
    assign o_empty = (r_rq_cnt == 2'd0);
    assign o_res = r_rq[r_rq_rd];

    always_comb begin
        n_res.status = r_status;
        n_res.live = r_live;
        n_res.left = r_left;
        n_res.top_bid = 16'(r_bb);
        n_res.bid_present = r_bp;
        n_res.top_ask = 16'(r_ba);
        n_res.ask_present = r_ap;
    end

    // Memory ports.
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_ent <= r_ent_mem[i_cmd.id];
        end
        if (r_state == S_READ) begin
            if (r_cmd.kind == K_ADD) begin
                r_tot <= r_cmd.is_ask ? r_ask_mem[r_cmd.price] : r_bid_mem[r_cmd.price];
            end else begin
                r_tot <= e_side ? r_ask_mem[e_price] : r_bid_mem[e_price];
            end
        end
        if (r_state == S_WRITE) begin
            if (r_cmd.kind == K_ADD && !e_valid) begin
                r_ent_mem[r_cmd.id] <= {1'b1, r_cmd.is_ask, r_cmd.price, r_cmd.amount};
            end else if (r_cmd.kind == K_REDUCE && e_valid) begin
                r_ent_mem[r_cmd.id] <= (r_cut == e_qty)
                    ? '0 : {1'b1, e_side, e_price, e_qty - r_cut};
            end
            if (upd) begin
                if (r_side) begin
                    r_ask_mem[r_lvl] <= (r_cmd.kind == K_ADD)
                        ? r_tot + TOT_W'(r_cmd.amount) : r_tot - TOT_W'(r_cut);
                end else begin
                    r_bid_mem[r_lvl] <= (r_cmd.kind == K_ADD)
                        ? r_tot + TOT_W'(r_cmd.amount) : r_tot - TOT_W'(r_cut);
                end
            end
        end
        if (r_state == S_CLEAR) begin
            r_ent_mem[r_clr] <= '0;
            r_bid_mem[r_clr[LV_W-1:0]] <= '0;
            r_ask_mem[r_clr[LV_W-1:0]] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_scan <= '0;
            r_bid_nz <= '0;
            r_ask_nz <= '0;
            r_rq_rd <= 1'b0;
            r_rq_wr <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (pop_acc) begin
                r_rq_rd <= ~r_rq_rd;
            end
            r_rq_cnt <= r_rq_cnt - {1'b0, pop_acc}
                + {1'b0, (r_state == S_DONE)};
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ID_W'(NUM_ORDERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_cmd.kind == K_ADD) begin
                        r_side <= r_cmd.is_ask;
                        r_lvl <= r_cmd.price;
                    end else begin
                        r_side <= e_side;
                        r_lvl <= e_price;
                    end
                    r_cut <= (r_cmd.amount < e_qty) ? r_cmd.amount : e_qty;
                    r_state <= S_LVL;
                end
                S_LVL: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_status <= r_cmd.rej_status;
                    r_live <= r_cmd.report_order && e_valid;
                    r_left <= (r_cmd.report_order && e_valid) ? e_qty : '0;
                    unique case (r_cmd.kind)
                        K_ADD: begin
                            if (e_valid) begin
                                r_status <= ST_ADD_REF;
                            end else begin
                                r_live <= 1'b1;
                                r_left <= r_cmd.amount;
                                if (r_cmd.is_ask) begin
                                    r_ask_nz[r_lvl] <= (r_tot + TOT_W'(r_cmd.amount)) != '0;
                                end else begin
                                    r_bid_nz[r_lvl] <= (r_tot + TOT_W'(r_cmd.amount)) != '0;
                                end
                            end
                        end
                        K_REDUCE: begin
                            if (!e_valid) begin
                                r_status <= ST_NOT_LIVE;
                            end else begin
                                if (r_cut == e_qty) begin
                                    r_live <= 1'b0;
                                    r_left <= '0;
                                end else begin
                                    r_left <= e_qty - r_cut;
                                end
                                if (r_side) begin
                                    r_ask_nz[r_lvl] <= (r_tot - TOT_W'(r_cut)) != '0;
                                end else begin
                                    r_bid_nz[r_lvl] <= (r_tot - TOT_W'(r_cut)) != '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_scan <= '0;
                    r_bp <= 1'b0;
                    r_ap <= 1'b0;
                    r_bb <= '0;
                    r_ba <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Bid walks down from the top level, ask walks up from zero.
                    if (!r_bp && r_bid_nz[hi_idx]) begin
                        r_bp <= 1'b1;
                        r_bb <= hi_idx;
                    end
                    if (!r_ap && r_ask_nz[lo_idx]) begin
                        r_ap <= 1'b1;
                        r_ba <= lo_idx;
                    end
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == (LV_W+1)'(NUM_LEVELS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_rq_wr <= ~r_rq_wr;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_rq[r_rq_wr] <= n_res;
        end
    end
endmodule

>>> rtl/core/limit_order_book_engine.sv
// Top level of the limit order book engine: front classifier and back executor.
// A beat passes through the command queue, the table and total read-modify-write
// (read, level and write states), the level scan and the result queue.
// The back end takes no new command until the scan of the last one has finished, nor while the result queue is full.
// Reset is synchronous and active low; afterwards the order table and level totals are
// cleared by a pass, during which no beat leaves the command queue.
module limit_order_book_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_operation,
    input  logic [15:0] i_order_ref,
    input  logic        i_is_ask,
    input  logic [15:0] i_price_level,
    input  logic [31:0] i_amount,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic        o_order_live,
    output logic [31:0] o_order_left,
    output logic [15:0] o_top_bid,
    output logic        o_bid_present,
    output logic [15:0] o_top_ask,
    output logic        o_ask_present
);
    import lobe_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;
    t_result res;

    lobe_front u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full),
        .i_operation, .i_order_ref, .i_is_ask, .i_price_level, .i_amount,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    lobe_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_empty(empty), .i_pop(pop), .o_res(res)
    );

    assign o_status      = res.status;
    assign o_order_live  = res.live;
    assign o_order_left  = res.left;
    assign o_top_bid     = res.top_bid;
    assign o_bid_present = res.bid_present;
    assign o_top_ask     = res.top_ask;
    assign o_ask_present = res.ask_present;
endmodule
